// File: rtl/hsd_pkg.sv
`default_nettype none

package hsd_pkg;

	localparam int IDX_W = 9;
	localparam int SYM_W = 8;
	localparam int REP_W = 32;

	localparam logic [1:0] ERR_NONE  = 2'd0;
	localparam logic [1:0] ERR_TREE  = 2'd1;
	localparam logic [1:0] ERR_TRUNC = 2'd2;

	typedef struct packed {
		logic [SYM_W-1:0] data_byte;
		logic             stream_end;
	} comp_item_t;

	typedef struct packed {
		logic [SYM_W-1:0] symbol;
		logic [REP_W-1:0] repeat_count;
		logic             final_symbol;
		logic             run_last;
		logic [1:0]       error_code;
	} dec_item_t;

	// A leaf keeps its symbol in the low bits of the right field.
	typedef struct packed {
		logic             leaf;
		logic [IDX_W-1:0] left;
		logic [IDX_W-1:0] right;
	} node_entry_t;

	typedef struct packed {
		logic      push;
		dec_item_t item;
		logic      flush;
		logic      trunc;
	} emit_ctl_t;

	typedef struct packed {
		logic push_ok;
		logic out_free;
	} emit_sts_t;

endpackage

`default_nettype wire

// File: rtl/huffman_stream_decoder_core.sv
`default_nettype none

// Channel   Signals                              Role
// comp      comp_valid, comp_stall, comp_data    compressed bytes in, bit 7 first
// dec       dec_valid, dec_stall, dec_data       decoded symbols and status out
//
// Each byte is accepted, then its bits are taken in turn, with a resolve step
// when its last bit started a node lookup, and then the byte is closed out. The
// bit loop runs one tree step per cycle, unless dec holds it, through the node
// RAM, whose registered read data selects the next address. Reset returns to
// the tree header; the RAMs need no clearing. A stall on dec holds the bit
// engine once its hold slot and output register are both full.
module huffman_stream_decoder_core import hsd_pkg::*; #(
	parameter int ALPHABET_SIZE = 256,
	parameter int NODE_DEPTH    = 511,
	parameter int COUNT_BITS    = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       comp_valid,
	output logic       comp_stall,
	input  comp_item_t comp_data,
	output logic       dec_valid,
	input  logic       dec_stall,
	output dec_item_t  dec_data
);

	localparam int NAW = $clog2(NODE_DEPTH);
	localparam int SAW = $clog2(ALPHABET_SIZE);
	localparam int SPW = $clog2(ALPHABET_SIZE + 1);
	localparam int LCW = $clog2(COUNT_BITS);
	localparam logic [IDX_W-1:0] NODE_LIMIT  = IDX_W'(NODE_DEPTH);
	localparam logic [SPW-1:0]   STACK_LIMIT = SPW'(ALPHABET_SIZE);
	localparam logic [LCW-1:0]   LEN_LAST    = LCW'(COUNT_BITS - 1);

	typedef enum logic [1:0] {ST_IDLE, ST_BITS, ST_RESOLVE, ST_FLUSH} ctl_state_t;
	typedef enum logic [2:0] {
		PH_TREE, PH_LEAF, PH_LENGTH, PH_DATA, PH_DONE, PH_ERROR
	} phase_t;

	ctl_state_t              state_q, state_d;
	phase_t                  phase_q, phase_d, ph;
	logic [SYM_W-1:0]        byte_q, byte_d;
	logic                    end_q, end_d;
	logic [2:0]              bit_cnt_q, bit_cnt_d;
	logic [SPW-1:0]          sp_q, sp_d;
	logic [IDX_W-1:0]        nc_q, nc_d;
	logic [2:0]              leaf_cnt_q, leaf_cnt_d;
	logic [SYM_W-2:0]        sym_q, sym_d;
	logic [COUNT_BITS-2:0]   len_q, len_d;
	logic [LCW-1:0]          len_cnt_q, len_cnt_d;
	logic [COUNT_BITS-1:0]   syms_q, syms_d;
	logic                    one_left_q, one_left_d;
	logic                    at_root_q, at_root_d;
	logic                    pend_q, pend_d;
	node_entry_t             root_q;

	logic                    node_we, node_re;
	logic [IDX_W-1:0]        node_waddr, node_raddr;
	node_entry_t             node_wdata, node_rdata, cur;
	logic                    stk_we, stk_re;
	logic [IDX_W-1:0]        stk_wdata, stk_rdata;
	logic [SPW-1:0]          stk_top;

	emit_ctl_t               ectl;
	emit_sts_t               ests;
	logic                    bit_go, step, b, trunc;
	logic [COUNT_BITS-1:0]   cnt_val;

	hsd_node_ram #(.DEPTH(NODE_DEPTH)) u_node_ram (
		.clk   (clk),
		.we    (node_we),
		.waddr (node_waddr[NAW-1:0]),
		.wdata (node_wdata),
		.re    (node_re),
		.raddr (node_raddr[NAW-1:0]),
		.rdata (node_rdata)
	);

	hsd_stack_ram #(.DEPTH(ALPHABET_SIZE)) u_stack_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (sp_q[SAW-1:0]),
		.wdata (stk_wdata),
		.re    (stk_re),
		.raddr (stk_top[SAW-1:0]),
		.rdata (stk_rdata)
	);

	hsd_out_stage u_out_stage (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ectl),
		.sts    (ests),
		.valid  (dec_valid),
		.stall  (dec_stall),
		.data   (dec_data)
	);

	assign comp_stall = (state_q != ST_IDLE);
	assign bit_go     = (state_q == ST_BITS) && ests.push_ok;
	assign step       = bit_go || ((state_q == ST_RESOLVE) && ests.push_ok);
	assign b          = byte_q[SYM_W-1];
	assign stk_top    = sp_q - SPW'(1);
	assign trunc      = end_q && (phase_q != PH_DONE) && (phase_q != PH_ERROR);
	assign cnt_val    = {len_q, b};

	// The current node is the root after a leaf, otherwise the last lookup.
	assign cur = (pend_q ? node_rdata.leaf : at_root_q) ? root_q : node_rdata;

	always_comb begin
		state_d    = state_q;
		phase_d    = phase_q;
		byte_d     = byte_q;
		end_d      = end_q;
		bit_cnt_d  = bit_cnt_q;
		sp_d       = sp_q;
		nc_d       = nc_q;
		leaf_cnt_d = leaf_cnt_q;
		sym_d      = sym_q;
		len_d      = len_q;
		len_cnt_d  = len_cnt_q;
		syms_d     = syms_q;
		one_left_d = one_left_q;
		at_root_d  = at_root_q;
		pend_d     = pend_q;
		node_we    = 1'b0;
		node_waddr = '0;
		node_wdata = '0;
		node_re    = 1'b0;
		node_raddr = '0;
		stk_we     = 1'b0;
		stk_wdata  = '0;
		stk_re     = 1'b0;
		ectl       = '0;
		ph         = phase_q;

		// A lookup issued by the previous bit is settled before this bit.
		if (step) begin
			pend_d = 1'b0;
			if (pend_q) begin
				at_root_d = node_rdata.leaf;
			end
			if (pend_q && node_rdata.leaf) begin
				syms_d      = syms_q - COUNT_BITS'(1);
				one_left_d  = (syms_q == COUNT_BITS'(2));
				ectl.push   = 1'b1;
				ectl.item   = '{symbol: node_rdata.right[SYM_W-1:0],
					repeat_count: REP_W'(1), final_symbol: one_left_q,
					run_last: 1'b0, error_code: ERR_NONE};
				if (one_left_q) begin
					ph = PH_DONE;
				end
			end
			phase_d = ph;
		end

		if (bit_go) begin
			case (ph)
				PH_TREE: begin
					if (nc_q >= NODE_LIMIT || (!b && sp_q == STACK_LIMIT)) begin
						ectl.push = 1'b1;
						ectl.item = '{symbol: '0, repeat_count: '0, final_symbol: 1'b0,
							run_last: 1'b0, error_code: ERR_TREE};
						phase_d   = PH_ERROR;
					end else if (b) begin
						phase_d    = PH_LEAF;
						leaf_cnt_d = '0;
						stk_re     = 1'b1;
						nc_d       = nc_q + IDX_W'(1);
					end else begin
						node_we    = 1'b1;
						node_waddr = nc_q;
						node_wdata = '{leaf: 1'b0, left: nc_q + IDX_W'(1), right: '0};
						stk_we     = 1'b1;
						stk_wdata  = nc_q;
						sp_d       = sp_q + SPW'(1);
						nc_d       = nc_q + IDX_W'(1);
					end
				end
				PH_LEAF: begin
					sym_d      = {sym_q[SYM_W-3:0], b};
					leaf_cnt_d = leaf_cnt_q + 3'd1;
					// The waiting parent gets its right child while the symbol shifts in.
					if (leaf_cnt_q == 3'd0 && sp_q != '0) begin
						node_we    = 1'b1;
						node_waddr = stk_rdata;
						node_wdata = '{leaf: 1'b0, left: stk_rdata + IDX_W'(1), right: nc_q};
					end
					if (leaf_cnt_q == 3'd7) begin
						node_we    = 1'b1;
						node_waddr = nc_q - IDX_W'(1);
						node_wdata = '{leaf: 1'b1, left: '0, right: IDX_W'({sym_q, b})};
						if (sp_q == '0) begin
							phase_d = PH_LENGTH;
						end else begin
							sp_d    = sp_q - SPW'(1);
							phase_d = PH_TREE;
						end
					end
				end
				PH_LENGTH: begin
					len_d     = {len_q[COUNT_BITS-3:0], b};
					len_cnt_d = len_cnt_q + LCW'(1);
					if (len_cnt_q == LEN_LAST) begin
						syms_d     = cnt_val;
						one_left_d = (cnt_val == COUNT_BITS'(1));
						at_root_d  = 1'b1;
						if (cnt_val == '0) begin
							phase_d = PH_DONE;
						end else if (root_q.leaf) begin
							ectl.push = 1'b1;
							ectl.item = '{symbol: root_q.right[SYM_W-1:0],
								repeat_count: REP_W'(cnt_val), final_symbol: 1'b1,
								run_last: 1'b0, error_code: ERR_NONE};
							syms_d    = '0;
							phase_d   = PH_DONE;
						end else begin
							phase_d = PH_DATA;
						end
					end
				end
				PH_DATA: begin
					node_re    = 1'b1;
					node_raddr = b ? cur.right : cur.left;
					pend_d     = 1'b1;
				end
				default: begin
				end
			endcase
		end

		case (state_q)
			ST_IDLE: begin
				if (comp_valid) begin
					byte_d    = comp_data.data_byte;
					end_d     = comp_data.stream_end;
					bit_cnt_d = '0;
					state_d   = ST_BITS;
				end
			end
			ST_BITS: begin
				if (bit_go) begin
					byte_d    = {byte_q[SYM_W-2:0], 1'b0};
					bit_cnt_d = bit_cnt_q + 3'd1;
					if (bit_cnt_q == 3'd7) begin
						state_d = pend_d ? ST_RESOLVE : ST_FLUSH;
					end
				end
			end
			ST_RESOLVE: begin
				if (step) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (ests.out_free) begin
					ectl.flush = 1'b1;
					ectl.trunc = trunc;
					if (end_q) begin
						phase_d    = PH_TREE;
						sp_d       = '0;
						nc_d       = '0;
						leaf_cnt_d = '0;
						len_cnt_d  = '0;
						syms_d     = '0;
						one_left_d = 1'b0;
						at_root_d  = 1'b1;
						pend_d     = 1'b0;
					end
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			phase_q    <= PH_TREE;
			end_q      <= 1'b0;
			bit_cnt_q  <= '0;
			sp_q       <= '0;
			nc_q       <= '0;
			leaf_cnt_q <= '0;
			len_cnt_q  <= '0;
			syms_q     <= '0;
			one_left_q <= 1'b0;
			at_root_q  <= 1'b1;
			pend_q     <= 1'b0;
		end else begin
			state_q    <= state_d;
			phase_q    <= phase_d;
			end_q      <= end_d;
			bit_cnt_q  <= bit_cnt_d;
			sp_q       <= sp_d;
			nc_q       <= nc_d;
			leaf_cnt_q <= leaf_cnt_d;
			len_cnt_q  <= len_cnt_d;
			syms_q     <= syms_d;
			one_left_q <= one_left_d;
			at_root_q  <= at_root_d;
			pend_q     <= pend_d;
		end
	end

	// The root entry is mirrored in a register so that it never costs a lookup.
	always_ff @(posedge clk) begin
		byte_q <= byte_d;
		sym_q  <= sym_d;
		len_q  <= len_d;
		if (node_we && node_waddr == '0) begin
			root_q <= node_wdata;
		end
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		comp_valid && !comp_stall |=> comp_stall)
		else $error("Input taken while a byte was still in progress.");

	a_tree_error_item: assert property (@(posedge clk) disable iff (!arst_n)
		dec_valid && dec_data.error_code == ERR_TREE |->
		dec_data.repeat_count == '0 && !dec_data.final_symbol)
		else $error("Tree error item carries symbol data.");

	a_lookup_in_data: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> phase_q == PH_DATA)
		else $error("Node lookup outstanding outside the code walk.");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FLUSH && ests.out_free && end_q |=>
		phase_q == PH_TREE && sp_q == '0 && nc_q == '0)
		else $error("Stream end did not return to the tree header.");

endmodule

`default_nettype wire

// File: rtl/hsd_node_ram.sv
`default_nettype none

module hsd_node_ram import hsd_pkg::*; #(
	parameter int DEPTH = 511
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  node_entry_t              wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output node_entry_t              rdata
);

	node_entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// File: rtl/hsd_stack_ram.sv
`default_nettype none

module hsd_stack_ram import hsd_pkg::*; #(
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [IDX_W-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [IDX_W-1:0]         rdata
);

	logic [IDX_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// File: rtl/hsd_out_stage.sv
`default_nettype none

module hsd_out_stage import hsd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  emit_ctl_t ctl,
	output emit_sts_t sts,
	output logic      valid,
	input  logic      stall,
	output dec_item_t data
);

	logic      out_valid_q;
	logic      hold_valid_q;
	dec_item_t out_q;
	dec_item_t hold_q;
	dec_item_t last_item;
	logic      out_free;

	// The newest result of a byte waits in the hold slot until it is known
	// whether it is the last one of that byte.
	assign out_free     = !out_valid_q || !stall;
	assign sts.out_free = out_free;
	assign sts.push_ok  = !hold_valid_q || out_free;
	assign valid        = out_valid_q;
	assign data         = out_q;

	always_comb begin
		last_item          = hold_q;
		last_item.run_last = 1'b1;
		if (ctl.trunc) begin
			last_item.error_code = ERR_TRUNC;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			hold_valid_q <= 1'b0;
		end else if (ctl.push) begin
			hold_valid_q <= 1'b1;
			if (hold_valid_q) begin
				out_valid_q <= 1'b1;
			end else if (!stall) begin
				out_valid_q <= 1'b0;
			end
		end else if (ctl.flush) begin
			hold_valid_q <= 1'b0;
			if (hold_valid_q || ctl.trunc) begin
				out_valid_q <= 1'b1;
			end else if (!stall) begin
				out_valid_q <= 1'b0;
			end
		end else if (!stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			hold_q <= ctl.item;
			if (hold_valid_q) begin
				out_q <= hold_q;
			end
		end else if (ctl.flush) begin
			if (hold_valid_q) begin
				out_q <= last_item;
			end else begin
				out_q <= '{symbol: '0, repeat_count: '0, final_symbol: 1'b0,
					run_last: 1'b1, error_code: ERR_TRUNC};
			end
		end
	end

endmodule

`default_nettype wire

// File: tb/tb.sv
`default_nettype none

module tb;
	import hsd_pkg::*;

	localparam int ALPHABET_SIZE = 256;
	localparam int NODE_DEPTH    = 511;
	localparam int COUNT_BITS    = 32;
	localparam int STACK_DEPTH   = ALPHABET_SIZE;
	localparam int MAX_RESULTS   = 8;
	localparam int SETTLE_CYCLES = 40;
	localparam int unsigned CYCLE_LIMIT = 1_000_000;

	typedef enum logic [2:0] {
		HDR_NODE,
		HDR_LEAF_SYM,
		HDR_COUNT,
		CODE_WALK,
		STREAM_DONE,
		STREAM_BAD
	} walk_phase_t;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       comp_valid = 1'b0;
	logic       comp_stall;
	comp_item_t comp_data = '0;
	logic       dec_valid;
	logic       dec_stall = 1'b0;
	dec_item_t  dec_data;

	// Decoder state as the predictor sees it.
	node_entry_t tree_nodes [NODE_DEPTH];
	logic [IDX_W-1:0] pend_nodes [STACK_DEPTH];
	int          pend_depth;
	int          nodes_built;
	walk_phase_t walk_phase;
	int          leaf_bits;
	logic [COUNT_BITS-1:0] count_shift;
	int          count_bits_left;
	logic [REP_W-1:0] symbols_due;
	logic [IDX_W-1:0] walk_at;

	dec_item_t byte_res [MAX_RESULTS];
	int        n_res;
	dec_item_t pending_results [$];

	// Stream builder state.
	bit         code_bits [$];
	logic [7:0] sym_pool [$];
	logic [7:0] last_sym = 8'h00;
	logic       shape_leaf [NODE_DEPTH];
	int         shape_left [NODE_DEPTH];
	int         shape_right [NODE_DEPTH];

	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_left = 0;
	int bytes_sent = 0;
	int fail_cnt = 0;
	int unsigned cycle_cnt = 0;

	huffman_stream_decoder_core #(
		.ALPHABET_SIZE(ALPHABET_SIZE),
		.NODE_DEPTH(NODE_DEPTH),
		.COUNT_BITS(COUNT_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.comp_valid(comp_valid),
		.comp_stall(comp_stall),
		.comp_data(comp_data),
		.dec_valid(dec_valid),
		.dec_stall(dec_stall),
		.dec_data(dec_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic void restart_stream();
		pend_depth = 0;
		nodes_built = 0;
		walk_phase = HDR_NODE;
		leaf_bits = 0;
		count_shift = '0;
		count_bits_left = COUNT_BITS;
		symbols_due = '0;
		walk_at = '0;
	endfunction

	function automatic void add_result(input logic [7:0] sym, input logic [31:0] rep,
			input logic fin, input logic [1:0] err);
		if (n_res < MAX_RESULTS) begin
			byte_res[n_res] = '{symbol: sym, repeat_count: rep, final_symbol: fin,
				run_last: 1'b0, error_code: err};
			n_res++;
		end
	endfunction

	function automatic void predict_byte(input comp_item_t it);
		logic             b;
		node_entry_t      cur;
		node_entry_t      nxt;
		logic [IDX_W-1:0] nxt_idx;
		n_res = 0;
		for (int i = 7; i >= 0; i--) begin
			b = it.data_byte[i];
			case (walk_phase)
			HDR_NODE: begin
				if (nodes_built >= NODE_DEPTH || (!b && pend_depth >= STACK_DEPTH)) begin
					add_result(8'h00, 32'd0, 1'b0, ERR_TREE);
					walk_phase = STREAM_BAD;
				end else begin
					if (b) begin
						tree_nodes[nodes_built] = '{leaf: 1'b1, left: '0, right: '0};
						leaf_bits = 8;
						walk_phase = HDR_LEAF_SYM;
					end else begin
						tree_nodes[nodes_built] = '{leaf: 1'b0,
							left: IDX_W'(nodes_built + 1), right: '0};
						pend_nodes[pend_depth] = IDX_W'(nodes_built);
						pend_depth++;
					end
					nodes_built++;
				end
			end
			HDR_LEAF_SYM: begin
				tree_nodes[nodes_built - 1].right =
					{1'b0, tree_nodes[nodes_built - 1].right[6:0], b};
				leaf_bits--;
				if (leaf_bits == 0) begin
					if (pend_depth == 0) begin
						walk_phase = HDR_COUNT;
					end else begin
						pend_depth--;
						tree_nodes[pend_nodes[pend_depth]].right = IDX_W'(nodes_built);
						walk_phase = HDR_NODE;
					end
				end
			end
			HDR_COUNT: begin
				count_shift = {count_shift[COUNT_BITS-2:0], b};
				count_bits_left--;
				if (count_bits_left == 0) begin
					symbols_due = count_shift;
					walk_at = '0;
					if (symbols_due == 0) begin
						walk_phase = STREAM_DONE;
					end else if (tree_nodes[0].leaf) begin
						add_result(tree_nodes[0].right[7:0], symbols_due, 1'b1, ERR_NONE);
						symbols_due = '0;
						walk_phase = STREAM_DONE;
					end else begin
						walk_phase = CODE_WALK;
					end
				end
			end
			CODE_WALK: begin
				cur = (walk_at < NODE_DEPTH) ? tree_nodes[walk_at] : '0;
				nxt_idx = b ? cur.right : cur.left;
				nxt = (nxt_idx < NODE_DEPTH) ? tree_nodes[nxt_idx] : '0;
				if (!nxt.leaf) begin
					walk_at = nxt_idx;
				end else begin
					symbols_due--;
					add_result(nxt.right[7:0], 32'd1, symbols_due == 0, ERR_NONE);
					walk_at = '0;
					if (symbols_due == 0)
						walk_phase = STREAM_DONE;
				end
			end
			default: ;
			endcase
		end
		if (it.stream_end) begin
			if (walk_phase != STREAM_DONE && walk_phase != STREAM_BAD) begin
				if (n_res > 0)
					byte_res[n_res - 1].error_code = ERR_TRUNC;
				else
					add_result(8'h00, 32'd0, 1'b0, ERR_TRUNC);
			end
			restart_stream();
		end
		if (n_res > 0)
			byte_res[n_res - 1].run_last = 1'b1;
		for (int i = 0; i < n_res; i++)
			pending_results.push_back(byte_res[i]);
	endfunction

	// Receiver: a long hold when one is requested, random stalls otherwise.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			dec_stall <= 1'b1;
		end else begin
			dec_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		dec_item_t want;
		if (dec_valid && !dec_stall) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: symbol %0h repeat_count %0d error_code %0d",
					dec_data.symbol, dec_data.repeat_count, dec_data.error_code);
				fail_cnt++;
			end else begin
				want = pending_results.pop_front();
				if (dec_data.symbol !== want.symbol) begin
					$error("symbol: expected %0h, got %0h", want.symbol, dec_data.symbol);
					fail_cnt++;
				end
				if (dec_data.repeat_count !== want.repeat_count) begin
					$error("repeat_count: expected %0d, got %0d",
						want.repeat_count, dec_data.repeat_count);
					fail_cnt++;
				end
				if (dec_data.final_symbol !== want.final_symbol) begin
					$error("final_symbol: expected %0b, got %0b",
						want.final_symbol, dec_data.final_symbol);
					fail_cnt++;
				end
				if (dec_data.run_last !== want.run_last) begin
					$error("run_last: expected %0b, got %0b", want.run_last, dec_data.run_last);
					fail_cnt++;
				end
				if (dec_data.error_code !== want.error_code) begin
					$error("error_code: expected %0d, got %0d",
						want.error_code, dec_data.error_code);
					fail_cnt++;
				end
			end
		end
	end

	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("Verification failed");
		$finish;
	end

	task automatic send_byte(input logic [7:0] value, input logic last);
		comp_item_t it;
		it.data_byte = value;
		it.stream_end = last;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			comp_valid <= 1'b0;
			@(posedge clk);
		end
		comp_valid <= 1'b1;
		comp_data <= it;
		do
			@(posedge clk);
		while (comp_stall);
		predict_byte(it);
		bytes_sent++;
	endtask

	task automatic wait_for_results();
		comp_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic void push_field(input logic [31:0] value, input int width);
		for (int i = width - 1; i >= 0; i--)
			code_bits.push_back(value[i]);
	endfunction

	// Packs the bit queue into bytes, padding with random bits. Only the first
	// keep_bytes go out when keep_bytes is set; the last byte sent ends the stream.
	task automatic send_code_bits(input int keep_bytes);
		logic [7:0] value;
		int         n_bytes;
		while (code_bits.size() % 8 != 0)
			code_bits.push_back(1'($urandom_range(0, 1)));
		n_bytes = code_bits.size() / 8;
		if (keep_bytes > 0 && keep_bytes < n_bytes)
			n_bytes = keep_bytes;
		for (int i = 0; i < n_bytes; i++) begin
			for (int j = 0; j < 8; j++)
				value[7 - j] = code_bits[8 * i + j];
			send_byte(value, i == n_bytes - 1);
		end
		code_bits.delete();
	endtask

	// Builds a random full code tree in pre-order, the symbol count, and codes
	// found by random walks from the root, then sends the stream, cut to keep_bytes when that is set.
	task automatic send_stream(input int leaves, input int branch_pct, input logic [31:0] count,
			input int codes, input int right_pct, input int extra_bytes, input int keep_bytes);
		int         slots;
		int         leaves_todo;
		int         inner_todo;
		int         idx;
		int         node;
		bit         inner;
		bit         go_right;
		logic [7:0] sym;
		int         pend [$];
		slots = 1;
		leaves_todo = leaves;
		inner_todo = leaves - 1;
		idx = 0;
		while (leaves_todo + inner_todo > 0) begin
			if (inner_todo == 0)
				inner = 1'b0;
			else if (slots == 1)
				inner = 1'b1;
			else
				inner = ($urandom_range(0, 99) < branch_pct);
			if (inner) begin
				code_bits.push_back(1'b0);
				shape_leaf[idx] = 1'b0;
				shape_left[idx] = idx + 1;
				pend.push_back(idx);
				inner_todo--;
				slots++;
			end else begin
				if (sym_pool.size() != 0) begin
					sym = sym_pool.pop_front();
				end else begin
					case ($urandom_range(0, 9))
					0: sym = 8'h00;
					1: sym = 8'hFF;
					2: sym = last_sym;
					default: sym = 8'($urandom);
					endcase
				end
				last_sym = sym;
				code_bits.push_back(1'b1);
				push_field({24'd0, sym}, 8);
				shape_leaf[idx] = 1'b1;
				if (pend.size() != 0)
					shape_right[pend.pop_back()] = idx + 1;
				leaves_todo--;
				slots--;
			end
			idx++;
		end
		push_field(count, COUNT_BITS);
		repeat (codes) begin
			node = 0;
			while (!shape_leaf[node]) begin
				go_right = ($urandom_range(0, 99) < right_pct);
				code_bits.push_back(go_right);
				node = go_right ? shape_right[node] : shape_left[node];
			end
		end
		repeat (8 * extra_bytes) code_bits.push_back(1'($urandom_range(0, 1)));
		send_code_bits(keep_bytes);
	endtask

	task automatic test_extremes();
		sym_pool = '{8'h00, 8'hFF, 8'hFF};
		send_stream(3, 50, 32'd6, 6, 50, 0, 0);
		wait_for_results();
	endtask

	task automatic test_single_leaf();
		sym_pool = '{8'hA5};
		send_stream(1, 50, 32'hFFFF_FFFF, 0, 50, 0, 0);
		wait_for_results();
	endtask

	task automatic test_zero_count();
		send_stream(2, 50, 32'd0, 0, 50, 1, 0);
		wait_for_results();
	endtask

	task automatic test_truncation();
		send_byte(8'h00, 1'b1);
		send_stream(2, 50, 32'd40, 40, 50, 0, 8);
		wait_for_results();
	endtask

	task automatic test_tree_overflow();
		send_idle_pct = 0;
		stall_pct = 0;
		// A run of inner nodes one byte longer than the pending stack.
		repeat (STACK_DEPTH / 8 + 1) send_byte(8'h00, 1'b0);
		send_byte(8'($urandom), 1'b1);
		wait_for_results();
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		stall_pct = 0;
		hold_left = 400;
		send_stream(2, 50, 32'd120, 120, 50, 0, 0);
		wait_for_results();
	endtask

	task automatic test_random_streams(input int idle_pct, input int stall_in, input int n_items);
		int          stop_at;
		int          kind;
		int          leaves;
		logic [31:0] count;
		send_idle_pct = idle_pct;
		stall_pct = stall_in;
		stop_at = bytes_sent + n_items;
		while (bytes_sent < stop_at) begin
			kind = $urandom_range(0, 99);
			leaves = $urandom_range(2, 12);
			count = $urandom_range(1, 16);
			if (kind < 12) begin
				repeat ($urandom_range(0, 5)) send_byte(8'($urandom), 1'b0);
				send_byte(8'($urandom), 1'b1);
			end else if (kind < 18) begin
				count = (kind == 12) ? 32'hFFFF_FFFF : $urandom;
				send_stream(1, 50, count, 0, 50, $urandom_range(0, 1), 0);
			end else if (kind < 23) begin
				send_stream(1, 50, $urandom_range(0, 3), 0, 50, 0, 0);
			end else if (kind < 28) begin
				send_stream(leaves, $urandom_range(0, 100), 32'd0, 0, 50, 0, 0);
			end else if (kind < 38) begin
				send_stream(leaves, $urandom_range(0, 100), count, int'(count), 50, 0,
					$urandom_range(1, 10));
			end else begin
				send_stream(leaves, $urandom_range(0, 100), count, int'(count), 50,
					$urandom_range(0, 1), 0);
			end
		end
		wait_for_results();
	endtask

	initial begin
		restart_stream();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_single_leaf();
		test_zero_count();
		test_truncation();
		test_tree_overflow();
		test_backpressure();
		test_random_streams(0, 0, 12);
		test_random_streams(73, 0, 12);
		test_random_streams(0, 73, 12);
		test_random_streams(26, 26, 12);
		if (fail_cnt == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

`default_nettype wire
